// ===== hw/rtl/sha256_message_hasher_macros.svh =====
// Assertion macros for the SHA-256 message hasher.
`ifndef SHA256_MESSAGE_HASHER_MACROS_SVH
`define SHA256_MESSAGE_HASHER_MACROS_SVH

`ifndef SYNTHESIS

`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha256_message_hasher: same-cycle check failed");

`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha256_message_hasher: next-cycle check failed");

`else

`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/sha_pkg.sv =====
// Shared types, constants and round functions of the SHA-256 message hasher.
`timescale 1ns / 1ps

package sha_pkg;

  typedef enum logic [3:0] {
    ST_IN   = 4'b0001,
    ST_PAD  = 4'b0010,
    ST_COMP = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  localparam logic [6:0] CNT_LAST    = 7'd66;
  localparam logic [6:0] CNT_RAM_END = 7'd16;
  localparam logic [6:0] CNT_SCHED_END = 7'd64;
  localparam logic [6:0] CNT_ROUND_BEG = 7'd2;
  localparam logic [6:0] CNT_ROUND_END = 7'd65;
  localparam logic [3:0] POS_LEN_HI  = 4'd14;
  localparam logic [3:0] POS_LAST    = 4'd15;
  localparam logic [2:0] FULL_BYTES  = 3'd4;
  localparam logic [31:0] PAD_MARKER = 32'h8000_0000;

  localparam logic [31:0] HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

// ===== hw/rtl/sha_ifs.sv =====
// Beat channel interfaces for message input and digest output.
`timescale 1ns / 1ps

interface sha_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  valid_bytes;
  logic        final_word;

  modport source(output valid, message_word, valid_bytes, final_word, input ready);
  modport sink(input valid, message_word, valid_bytes, final_word, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_part0;
  logic [63:0] digest_part1;
  logic [63:0] digest_part2;
  logic [63:0] digest_part3;

  modport source(output valid, digest_part0, digest_part1, digest_part2, digest_part3,
                 input ready);
  modport sink(input valid, digest_part0, digest_part1, digest_part2, digest_part3,
               output ready);
endinterface

// ===== hw/rtl/sha256_message_hasher.sv =====
// SHA-256 message hasher top level: block buffer RAM, schedule window and round engine.
// Input words are taken one per cycle into the 16-word block RAM while in_ch.ready is high
// (state ST_IN); each full block then occupies the round engine, one round per cycle plus fill and chain add.
// A final beat adds padding words and one or two blocks before the digest beat.
// Synchronous active-low reset restores the initial hash and clears length and position.
`timescale 1ns / 1ps
`include "sha256_message_hasher_macros.svh"

module sha256_message_hasher (
  input  logic            clk,
  input  logic            rst_n,
  sha_in_if.sink          in_ch,
  sha_out_if.source       out_ch
);

  sha_pkg::state_t state_r, state_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] bitcnt_r, bitcnt_nxt;
  logic        marker_r, marker_nxt;
  logic        hi_r, hi_nxt;
  logic        done_r, done_nxt;
  logic        pad_r, pad_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        load_out;

  logic        in_fire;
  logic [2:0]  nbytes;
  logic        ram_we;
  logic [31:0] ram_wdata;
  logic [31:0] ram_rdata;

  logic [31:0] chain_r [8];
  logic [31:0] work_r [8];
  logic [31:0] sched_r [16];
  logic [31:0] kw_r;
  logic [31:0] dig_r [8];

  logic [5:0]  sched_idx;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic        sched_en;
  logic        round_en;

  assign in_ch.ready = (state_r == sha_pkg::ST_IN);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign nbytes      = (in_ch.valid_bytes > sha_pkg::FULL_BYTES) ? sha_pkg::FULL_BYTES
                                                                 : in_ch.valid_bytes;

  sha_ram #(.WIDTH(32), .DEPTH(16)) u_block_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r),
    .wdata (ram_wdata),
    .raddr (cnt_r[3:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    bitcnt_nxt    = bitcnt_r;
    marker_nxt    = marker_r;
    hi_nxt        = hi_r;
    done_nxt      = done_r;
    pad_nxt       = pad_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    load_out      = 1'b0;
    ram_we        = 1'b0;
    ram_wdata     = '0;
    unique case (state_r)
      sha_pkg::ST_IN: begin
        if (in_fire) begin
          ram_we  = 1'b1;
          pos_nxt = pos_r + 4'd1;
          cnt_nxt = '0;
          if (in_ch.final_word) begin
            bitcnt_nxt = bitcnt_r + {58'd0, nbytes, 3'b000};
            marker_nxt = (nbytes == sha_pkg::FULL_BYTES);
            pad_nxt    = 1'b1;
            case (nbytes)
              3'd0:    ram_wdata = sha_pkg::PAD_MARKER;
              3'd1:    ram_wdata = {in_ch.message_word[31:24], 24'h80_0000};
              3'd2:    ram_wdata = {in_ch.message_word[31:16], 16'h8000};
              3'd3:    ram_wdata = {in_ch.message_word[31:8], 8'h80};
              default: ram_wdata = in_ch.message_word;
            endcase
            state_nxt = (pos_r == sha_pkg::POS_LAST) ? sha_pkg::ST_COMP : sha_pkg::ST_PAD;
          end else begin
            bitcnt_nxt = bitcnt_r + 64'd32;
            ram_wdata  = in_ch.message_word;
            state_nxt  = (pos_r == sha_pkg::POS_LAST) ? sha_pkg::ST_COMP : sha_pkg::ST_IN;
          end
        end
      end
      sha_pkg::ST_PAD: begin
        ram_we  = 1'b1;
        pos_nxt = pos_r + 4'd1;
        cnt_nxt = '0;
        if (marker_r) begin
          ram_wdata  = sha_pkg::PAD_MARKER;
          marker_nxt = 1'b0;
        end else if (pos_r == sha_pkg::POS_LEN_HI) begin
          ram_wdata = bitcnt_r[63:32];
          hi_nxt    = 1'b1;
        end else if ((pos_r == sha_pkg::POS_LAST) && hi_r) begin
          ram_wdata  = bitcnt_r[31:0];
          done_nxt   = 1'b1;
          bitcnt_nxt = '0;
        end
        if (pos_r == sha_pkg::POS_LAST) begin
          state_nxt = sha_pkg::ST_COMP;
        end
      end
      sha_pkg::ST_COMP: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == sha_pkg::CNT_LAST) begin
          if (done_r) begin
            state_nxt = sha_pkg::ST_FIN;
          end else if (pad_r) begin
            state_nxt = sha_pkg::ST_PAD;
          end else begin
            state_nxt = sha_pkg::ST_IN;
          end
        end
      end
      sha_pkg::ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          done_nxt      = 1'b0;
          hi_nxt        = 1'b0;
          pad_nxt       = 1'b0;
          state_nxt     = sha_pkg::ST_IN;
        end
      end
      default: begin
        state_nxt = sha_pkg::ST_IN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha_pkg::ST_IN;
      pos_r       <= '0;
      cnt_r       <= '0;
      bitcnt_r    <= '0;
      marker_r    <= 1'b0;
      hi_r        <= 1'b0;
      done_r      <= 1'b0;
      pad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      bitcnt_r    <= bitcnt_nxt;
      marker_r    <= marker_nxt;
      hi_r        <= hi_nxt;
      done_r      <= done_nxt;
      pad_r       <= pad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The schedule stage registers word t, folded with K, in the cycle before round t uses it.
  assign sched_idx = cnt_r[5:0] - 6'd1;
  assign sched_en  = (state_r == sha_pkg::ST_COMP) && (cnt_r != '0) &&
                     (cnt_r <= sha_pkg::CNT_SCHED_END);
  assign round_en  = (state_r == sha_pkg::ST_COMP) && (cnt_r >= sha_pkg::CNT_ROUND_BEG) &&
                     (cnt_r <= sha_pkg::CNT_ROUND_END);

  always_comb begin
    if (cnt_r <= sha_pkg::CNT_RAM_END) begin
      w_new = ram_rdata;
    end else begin
      w_new = sha_pkg::small_sigma1(sched_r[14]) + sched_r[9] +
              sha_pkg::small_sigma0(sched_r[1]) + sched_r[0];
    end
    t1 = work_r[7] + sha_pkg::big_sigma1(work_r[4]) +
         ((work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6])) + kw_r;
    t2 = sha_pkg::big_sigma0(work_r[0]) +
         ((work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]));
  end

  always_ff @(posedge clk) begin
    if (sched_en) begin
      for (int i = 0; i < 15; i++) begin
        sched_r[i] <= sched_r[i+1];
      end
      sched_r[15] <= w_new;
      kw_r        <= w_new + sha_pkg::ROUND_K[sched_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sha_pkg::ST_COMP && cnt_r == '0) begin
      for (int i = 0; i < 8; i++) begin
        work_r[i] <= chain_r[i];
      end
    end else if (round_en) begin
      work_r[7] <= work_r[6];
      work_r[6] <= work_r[5];
      work_r[5] <= work_r[4];
      work_r[4] <= work_r[3] + t1;
      work_r[3] <= work_r[2];
      work_r[2] <= work_r[1];
      work_r[1] <= work_r[0];
      work_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= sha_pkg::HASH_INIT[i];
      end
    end else if (state_r == sha_pkg::ST_COMP && cnt_r == sha_pkg::CNT_LAST) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= chain_r[i] + work_r[i];
      end
    end else if (load_out) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= sha_pkg::HASH_INIT[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      for (int i = 0; i < 8; i++) begin
        dig_r[i] <= chain_r[i];
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.digest_part0 = {dig_r[0], dig_r[1]};
  assign out_ch.digest_part1 = {dig_r[2], dig_r[3]};
  assign out_ch.digest_part2 = {dig_r[4], dig_r[5]};
  assign out_ch.digest_part3 = {dig_r[6], dig_r[7]};

  `SHA_ASSERT_IMP(a_no_write_in_comp, clk, rst_n, state_r == sha_pkg::ST_COMP, !ram_we)
  `SHA_ASSERT_IMP(a_fin_at_boundary, clk, rst_n, state_r == sha_pkg::ST_FIN,
                  done_r && hi_r && (pos_r == 4'd0) && !marker_r)
  `SHA_ASSERT_NXT(a_comp_runs, clk, rst_n,
                  (state_r == sha_pkg::ST_COMP) && (cnt_r != sha_pkg::CNT_LAST),
                  (state_r == sha_pkg::ST_COMP) && (cnt_r == $past(cnt_r) + 7'd1))

endmodule

// ===== hw/rtl/sha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== dv/sha256_message_hasher_tb.sv =====
// Self-checking testbench for the SHA-256 message hasher with a digest predictor.
`timescale 1ns / 1ps

module sha256_message_hasher_tb;

  localparam int RANDOM_ITEMS  = 730;
  localparam int QUIET_FROM    = 620;
  localparam int DRAIN_CYCLES  = 200;
  localparam int STALL_LIMIT   = 2000;

  localparam bit [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam bit [31:0] SHA_H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  class digest_scoreboard;
    bit [31:0]  chain_words [8];
    bit [31:0]  block_words [16];
    bit [3:0]   fill_pos;
    bit [63:0]  msg_bits;
    bit [255:0] digest_q [$];
    int         errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      chain_words = SHA_H0;
      msg_bits    = 64'd0;
      fill_pos    = 4'd0;
    endfunction

    function bit [31:0] rotr(bit [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      bit [31:0] sched [64];
      bit [31:0] v [8];
      bit [31:0] s0, s1, t1, t2;
      for (int i = 0; i < 16; i++) sched[i] = block_words[i];
      for (int i = 16; i < 64; i++) begin
        s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
        s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
        sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
      end
      v = chain_words;
      for (int r = 0; r < 64; r++) begin
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + sched[r];
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain_words[i] += v[i];
    endfunction

    function void absorb(bit [31:0] w);
      block_words[fill_pos] = w;
      fill_pos++;
      if (fill_pos == 4'd0) compress();
    endfunction

    function void note_input(bit [31:0] w, bit [2:0] nb, bit fin);
      int         nbytes;
      bit [31:0]  keep;
      bit [255:0] dgst;
      if (!fin) begin
        absorb(w);
        msg_bits += 64'd32;
        return;
      end
      nbytes = (nb > sha_pkg::FULL_BYTES) ? 4 : int'(nb);
      msg_bits += 64'(nbytes * 8);
      if (nbytes == 4) begin
        absorb(w);
        absorb(32'h8000_0000);
      end else begin
        keep = (nbytes == 0) ? 32'd0 : (32'hffff_ffff << (32 - 8 * nbytes));
        absorb((w & keep) | (32'h80 << (24 - 8 * nbytes)));
      end
      while (fill_pos != 4'd14) absorb(32'd0);
      absorb(msg_bits[63:32]);
      absorb(msg_bits[31:0]);
      dgst = {chain_words[0], chain_words[1], chain_words[2], chain_words[3],
              chain_words[4], chain_words[5], chain_words[6], chain_words[7]};
      digest_q = {digest_q, dgst};
      restart();
    endfunction

    function void check_digest(bit [63:0] p0, bit [63:0] p1, bit [63:0] p2, bit [63:0] p3);
      bit [255:0] want;
      bit [63:0]  got [4];
      bit [63:0]  exp_part;
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest beat %h %h %h %h", $time, p0, p1, p2, p3);
        errors++;
        return;
      end
      want = digest_q.pop_front();
      got = '{p0, p1, p2, p3};
      for (int i = 0; i < 4; i++) begin
        exp_part = want[255 - 64 * i -: 64];
        if (got[i] !== exp_part) begin
          $display("%0t: digest_part%0d expected %h actual %h", $time, i, exp_part, got[i]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return digest_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   idle_on;
  bit   quiet_tail;
  int   items_sent;
  int   stall_cycles;

  digest_scoreboard sb = new();

  sha_in_if  in_ch();
  sha_out_if out_ch();

  sha256_message_hasher DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The sender calls this at a rising edge; it returns at the edge that accepts the beat.
  task automatic send_beat(input logic [31:0] w, input logic [2:0] nb, input logic fin);
    if (idle_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.message_word <= w;
    in_ch.valid_bytes  <= nb;
    in_ch.final_word   <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(w, nb, fin);
    items_sent++;
  endtask

  task automatic send_message(input int nwords);
    logic [2:0] nb;
    for (int i = 0; i < nwords; i++) begin
      nb = ($urandom_range(0, 1) == 0) ? sha_pkg::FULL_BYTES : 3'($urandom_range(0, 7));
      send_beat($urandom, nb, 1'b0);
    end
    send_beat($urandom, 3'($urandom_range(0, 7)), 1'b1);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (quiet_tail || $urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      sb.check_digest(out_ch.digest_part0, out_ch.digest_part1,
                      out_ch.digest_part2, out_ch.digest_part3);
    end
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int nwords;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.message_word <= 32'd0;
    in_ch.valid_bytes  <= 3'd0;
    in_ch.final_word   <= 1'b0;
    idle_on            = 1'b1;
    quiet_tail         = 1'b0;
    items_sent         = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // An empty message, short finals with junk in the unused lanes, and oversized byte counts.
    send_beat(32'hdead_beef, 3'd0, 1'b1);
    send_beat(32'h6162_63ff, 3'd3, 1'b1);
    send_beat(32'hffff_ffff, 3'd1, 1'b1);
    send_beat(32'hffff_ffff, sha_pkg::FULL_BYTES, 1'b1);
    send_beat(32'h0000_0000, 3'd5, 1'b1);
    send_beat(32'h1234_5678, 3'd6, 1'b1);
    send_beat(32'hffff_ffff, 3'd7, 1'b1);
    send_beat(32'h0000_0000, 3'd0, 1'b0);
    send_beat(32'h8000_0001, 3'd2, 1'b1);
    // Fourteen full words leave no room for the length, so padding spills into a second block.
    for (int i = 0; i < 14; i++) send_beat($urandom, 3'(i), 1'b0);
    send_beat(32'ha5a5_5a5a, 3'd3, 1'b1);
    wait_drained();

    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= QUIET_FROM) quiet_tail = 1'b1;
      idle_on = ($urandom_range(0, 4) != 0);
      nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 18);
      send_message(nwords);
      if ($urandom_range(0, 11) == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d digests expected but never delivered", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
